FILE: rtl/core/dhbp_pkg.sv
package dhbp_pkg;

	localparam int CH_W  = 8;
	localparam int CNT_W = 7;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_DASH  = 8'h2d;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_F  = 8'h66;
	localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_F  = 8'h46;
	localparam logic [CH_W-1:0] HEX_TEN  = 8'd10;

	localparam logic [3:0] BYTE_COUNT_RST = 4'd6;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2,
		ST_TERM  = 2'd3
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [CH_W-1:0] c);
		hex_t h;
		logic [CH_W-1:0] t;
		h = '{ok: 1'b0, val: 4'd0};
		t = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
			h.ok = 1'b1;
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			t = c - CH_LO_A + HEX_TEN;
			h.ok = 1'b1;
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			t = c - CH_UP_A + HEX_TEN;
			h.ok = 1'b1;
		end
		h.val = t[3:0];
		return h;
	endfunction

endpackage

FILE: rtl/core/dashed_hex_byte_parser_top.sv
// An input transfer reaches its result through the input register and the result register.
// One character per cycle while in_stall is low; a character with no result gives no transfer.
// At most one result per character; the last byte and the OK status share one result.
// Reset (arst_n low, asynchronous): pipeline empty, parser at string start,
// byte_count back to 6.
module dashed_hex_byte_parser_top #(
	parameter int MAX_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [3:0]                 cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [dhbp_pkg::CH_W-1:0]  ch,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       byte_valid,
	output logic [7:0]                 byte_value,
	output logic [2:0]                 byte_index,
	output logic                       status_valid,
	output logic [1:0]                 status
);

	localparam int GIW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2,
		PH_DRAIN = 2'd3
	} phase_t;

	logic [3:0]                cnt_q;
	logic                      valid_s1;
	logic [dhbp_pkg::CH_W-1:0] ch_s1;
	phase_t                    phase_q, phase_d;
	logic [GIW-1:0]            gi_q, gi_d;
	logic [3:0]                held_q, held_d;
	logic [7:0]                acc_q, acc_d;
	logic                      start_q, start_d;

	logic                      adv, fire;
	logic                      res_v, res_bv, res_sv;
	logic [7:0]                res_val;
	logic [2:0]                res_idx;
	dhbp_pkg::status_t         res_st;
	dhbp_pkg::hex_t            hx;
	logic [dhbp_pkg::CNT_W-1:0] lim, gi_next;
	logic                      last;
	logic [7:0]                sep_val;
	logic                      is_nul, is_dash;

	assign adv      = !out_valid || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= dhbp_pkg::BYTE_COUNT_RST;
		end else if (cfg_wr_en) begin
			cnt_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= ch;
		end
	end

	// effective group limit: 0 acts as 1, clipped to MAX_BYTES
	always_comb begin
		if (cnt_q == 4'd0) begin
			lim = dhbp_pkg::CNT_W'(1);
		end else if (dhbp_pkg::CNT_W'(cnt_q) > dhbp_pkg::CNT_W'(MAX_BYTES)) begin
			lim = dhbp_pkg::CNT_W'(MAX_BYTES);
		end else begin
			lim = dhbp_pkg::CNT_W'(cnt_q);
		end
	end

	assign gi_next = dhbp_pkg::CNT_W'(gi_q) + dhbp_pkg::CNT_W'(1);
	assign last    = gi_next >= lim;
	assign hx      = dhbp_pkg::hex_decode(ch_s1);
	assign is_nul  = ch_s1 == dhbp_pkg::CH_NUL;
	assign is_dash = ch_s1 == dhbp_pkg::CH_DASH;
	assign sep_val = (phase_q == PH_ONE) ? {4'd0, held_q} : acc_q;

	always_comb begin
		res_v   = 1'b0;
		res_bv  = 1'b0;
		res_val = 8'd0;
		res_idx = 3'd0;
		res_sv  = 1'b0;
		res_st  = dhbp_pkg::ST_OK;
		phase_d = phase_q;
		gi_d    = gi_q;
		held_d  = held_q;
		acc_d   = acc_q;
		start_d = start_q;
		case (phase_q)
			PH_FIRST: begin
				if (is_nul && start_q) begin
					res_v  = 1'b1;
					res_sv = 1'b1;
					res_st = dhbp_pkg::ST_EMPTY;
				end else begin
					start_d = 1'b0;
					if (!hx.ok) begin
						res_v  = 1'b1;
						res_sv = 1'b1;
						res_st = dhbp_pkg::ST_BAD;
						phase_d = is_nul ? PH_FIRST : PH_DRAIN;
					end else begin
						held_d  = hx.val;
						phase_d = PH_ONE;
					end
				end
			end
			PH_ONE, PH_TWO: begin
				if (phase_q == PH_ONE && !is_nul && !is_dash) begin
					if (!hx.ok) begin
						res_v   = 1'b1;
						res_sv  = 1'b1;
						res_st  = dhbp_pkg::ST_BAD;
						phase_d = PH_DRAIN;
					end else begin
						acc_d   = {held_q, hx.val};
						phase_d = PH_TWO;
					end
				end else if (!last) begin
					res_v = 1'b1;
					if (!is_dash) begin
						res_sv  = 1'b1;
						res_st  = dhbp_pkg::ST_BAD;
						phase_d = is_nul ? PH_FIRST : PH_DRAIN;
					end else begin
						res_bv  = 1'b1;
						res_val = sep_val;
						res_idx = 3'(8'(gi_q));
						gi_d    = gi_q + GIW'(1);
						phase_d = PH_FIRST;
						held_d  = 4'd0;
						acc_d   = 8'd0;
					end
				end else begin
					res_v  = 1'b1;
					res_sv = 1'b1;
					if (!is_nul) begin
						res_st  = dhbp_pkg::ST_TERM;
						phase_d = PH_DRAIN;
					end else begin
						res_bv  = 1'b1;
						res_val = sep_val;
						res_idx = 3'(8'(gi_q));
						res_st  = dhbp_pkg::ST_OK;
						phase_d = PH_FIRST;
					end
				end
			end
			default: begin
				if (is_nul) begin
					phase_d = PH_FIRST;
				end
			end
		endcase
		// every way back to PH_FIRST other than after a dash is a restart
		if (phase_d == PH_FIRST && !(phase_q != PH_FIRST && res_bv && !res_sv)) begin
			gi_d    = '0;
			held_d  = 4'd0;
			acc_d   = 8'd0;
			start_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			gi_q         <= '0;
			held_q       <= 4'd0;
			acc_q        <= 8'd0;
			start_q      <= 1'b1;
			out_valid    <= 1'b0;
			byte_valid   <= 1'b0;
			byte_value   <= 8'd0;
			byte_index   <= 3'd0;
			status_valid <= 1'b0;
			status       <= dhbp_pkg::ST_OK;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				gi_q    <= gi_d;
				held_q  <= held_d;
				acc_q   <= acc_d;
				start_q <= start_d;
			end
			if (adv) begin
				out_valid <= fire && res_v;
			end
			if (fire && res_v) begin
				byte_valid   <= res_bv;
				byte_value   <= res_val;
				byte_index   <= res_idx;
				status_valid <= res_sv;
				status       <= res_st;
			end
		end
	end

`ifndef SYNTHESIS
	a_result_carries_something: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_valid || status_valid))
		else $error("result with neither byte nor status");

	a_byte_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (byte_value == 8'd0 && byte_index == 3'd0))
		else $error("byte fields not zero without a byte");

	a_final_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_valid && status_valid) |-> status == dhbp_pkg::ST_OK)
		else $error("final byte with an error status");

	a_drain_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DRAIN) |-> !start_q)
		else $error("draining while at string start");

	a_status_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_sv && is_nul) |=> (phase_q == PH_FIRST && start_q && gi_q == '0))
		else $error("parser not restarted after end of string");
`endif

endmodule
